// ===== sv/wpat_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the peer association table.
package wpat_pkg;

   localparam int MAC_W = 48;
   localparam int AID_W = 11;

   localparam logic [AID_W-1:0] AID_TOP  = 11'd2007;
   localparam logic [AID_W-1:0] AID_NONE = 11'h7FF;

   localparam logic [2:0] REQ_SET_STATUS = 3'd0;
   localparam logic [2:0] REQ_RESERVE    = 3'd1;
   localparam logic [2:0] REQ_RELEASE    = 3'd2;
   localparam logic [2:0] REQ_COMMIT     = 3'd3;
   localparam logic [2:0] REQ_CLEAR      = 3'd4;
   localparam logic [2:0] REQ_LOOKUP_MAC = 3'd5;
   localparam logic [2:0] REQ_LOOKUP_ID  = 3'd6;

   localparam logic [1:0] MS_ASSOCIATED = 2'd2;

   localparam logic [3:0] ERR_OK          = 4'd0;
   localparam logic [3:0] ERR_BAD_STATUS  = 4'd1;
   localparam logic [3:0] ERR_PEER_ASSOC  = 4'd2;
   localparam logic [3:0] ERR_ID_RANGE    = 4'd3;
   localparam logic [3:0] ERR_MISMATCH    = 4'd4;
   localparam logic [3:0] ERR_ID_USED     = 4'd5;
   localparam logic [3:0] ERR_NONE_FREE   = 4'd6;
   localparam logic [3:0] ERR_EPOCH_EXH   = 4'd7;
   localparam logic [3:0] ERR_TABLE_FULL  = 4'd8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_VIEW,
      ST_SCAN,
      ST_CHECK,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic [2:0]       req_type;
      logic [MAC_W-1:0] peer_mac;
      logic [1:0]       member_status;
      logic [AID_W-1:0] assoc_id;
   } request_type;

   typedef struct packed {
      logic [3:0]       error_code;
      logic             has_status;
      logic [1:0]       status_out;
      logic [AID_W-1:0] aid_out;
      logic [31:0]      generation_out;
      logic [31:0]      epoch_out;
      logic [MAC_W-1:0] station_mac;
      logic             old_has_status;
      logic [1:0]       old_status;
      logic [AID_W-1:0] old_aid;
      logic [31:0]      old_generation;
      logic [31:0]      old_epoch;
   } response_type;

   typedef struct packed {
      logic             valid;
      logic [MAC_W-1:0] mac;
      logic             has;
      logic [1:0]       st;
      logic [AID_W-1:0] aid;
      logic [AID_W-1:0] res;
   } slot_rec_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic valid;
      logic mac_hit;
      logic aid_hit;
      logic any_hit;
   } cell_stat_type;

endpackage

// ===== sv/wpat_cell.sv =====
`timescale 1ns / 1ps
// One peer slot: record storage, match logic and a two-entry ID scan stage.
module wpat_cell #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  wpat_pkg::cell_ctrl_type   ctrl,
   input  logic                      we,
   input  wpat_pkg::slot_rec_type    wr_rec,
   input  logic [COUNT_WIDTH-1:0]    wr_gen,
   input  logic [COUNT_WIDTH-1:0]    wr_ep,
   input  logic [wpat_pkg::MAC_W-1:0] probe_mac,
   input  logic [wpat_pkg::AID_W-1:0] probe_id,
   input  logic [wpat_pkg::AID_W-1:0] scan_in,
   output logic [wpat_pkg::AID_W-1:0] scan_out,
   output wpat_pkg::slot_rec_type    rec,
   output logic [COUNT_WIDTH-1:0]    gen,
   output logic [COUNT_WIDTH-1:0]    ep,
   output wpat_pkg::cell_stat_type   stat
);
   import wpat_pkg::*;

   logic             valid_ff, valid_in;
   logic             has_ff, has_in;
   logic [MAC_W-1:0] mac_ff, mac_in;
   logic [1:0]       st_ff, st_in;
   logic [AID_W-1:0] aid_ff, aid_in;
   logic [AID_W-1:0] res_ff, res_in;
   logic [COUNT_WIDTH-1:0] gen_ff, gen_in;
   logic [COUNT_WIDTH-1:0] ep_ff, ep_in;
   logic [AID_W-1:0] scan_a_ff, scan_a_in;
   logic [AID_W-1:0] scan_b_ff, scan_b_in;

   always_comb begin
      valid_in = valid_ff;
      has_in   = has_ff;
      mac_in   = mac_ff;
      st_in    = st_ff;
      aid_in   = aid_ff;
      res_in   = res_ff;
      gen_in   = gen_ff;
      ep_in    = ep_ff;
      if (we) begin
         valid_in = wr_rec.valid;
         has_in   = wr_rec.has;
         mac_in   = wr_rec.mac;
         st_in    = wr_rec.st;
         aid_in   = wr_rec.aid;
         res_in   = wr_rec.res;
         gen_in   = wr_gen;
         ep_in    = wr_ep;
      end
   end

   always_comb begin
      scan_a_in = scan_a_ff;
      scan_b_in = scan_b_ff;
      if (ctrl.load) begin
         scan_a_in = aid_ff;
         scan_b_in = res_ff;
      end else if (ctrl.shift) begin
         scan_a_in = scan_b_ff;
         scan_b_in = scan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         has_ff   <= 1'b0;
         aid_ff   <= '0;
         res_ff   <= '0;
         gen_ff   <= '0;
         ep_ff    <= '0;
      end else begin
         valid_ff <= valid_in;
         has_ff   <= has_in;
         aid_ff   <= aid_in;
         res_ff   <= res_in;
         gen_ff   <= gen_in;
         ep_ff    <= ep_in;
      end
   end

   always_ff @(posedge clock) begin
      mac_ff    <= mac_in;
      st_ff     <= st_in;
      scan_a_ff <= scan_a_in;
      scan_b_ff <= scan_b_in;
   end

   assign scan_out = scan_a_ff;
   assign rec      = '{valid: valid_ff, mac: mac_ff, has: has_ff, st: st_ff,
                       aid: aid_ff, res: res_ff};
   assign gen      = gen_ff;
   assign ep       = ep_ff;

   assign stat.valid   = valid_ff;
   assign stat.mac_hit = valid_ff && (mac_ff == probe_mac);
   assign stat.aid_hit = valid_ff && (aid_ff == probe_id);
   assign stat.any_hit = valid_ff && ((aid_ff == probe_id) || (res_ff == probe_id));

endmodule

// ===== sv/wlan_peer_association_table_unit.sv =====
`timescale 1ns / 1ps
// Peer association table top level: request sequencer and row of slot cells.
// Each request passes through the states MATCH, VIEW, SCAN, CHECK and APPLY
// before the next one is accepted; the result is presented in an output
// register and may wait there while the next request is accepted. The SCAN
// state holds the lowest-free-ID search: every held ID in the table is shifted
// one per cycle out of the cell chain and its successor probed against all
// cells. No clearing pass follows reset. The ID limit register is written
// through csr_wr_en and csr_wr_data; the user must write it only while the unit
// is idle, which the unit does not enforce. Values above 2007 act as 2007.
module wlan_peer_association_table_unit #(
   parameter int MAX_PEERS   = 64,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  wpat_pkg::request_type     req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output wpat_pkg::response_type    rsp_data,
   input  logic                      csr_wr_en,
   input  logic [wpat_pkg::AID_W-1:0] csr_wr_data
);
   import wpat_pkg::*;

   localparam int SCW = $clog2(2 * MAX_PEERS + 1);
   localparam logic [SCW-1:0] SCAN_LAST = SCW'(2 * MAX_PEERS);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   state_type state_ff, state_in;

   request_type          req_ff, req_in;
   logic [AID_W-1:0]     limit_ff, limit_in;
   logic [MAX_PEERS-1:0] mac_oh_ff, mac_oh_in;
   logic [MAX_PEERS-1:0] id_oh_ff, id_oh_in;
   logic [MAX_PEERS-1:0] free_oh_ff, free_oh_in;
   logic                 b_valid_ff, b_valid_in;
   logic                 b_has_ff, b_has_in;
   logic [1:0]           b_st_ff, b_st_in;
   logic [AID_W-1:0]     b_aid_ff, b_aid_in;
   logic [AID_W-1:0]     b_res_ff, b_res_in;
   logic [COUNT_WIDTH-1:0] b_gen_ff, b_gen_in;
   logic [COUNT_WIDTH-1:0] b_ep_ff, b_ep_in;
   logic [MAC_W-1:0]     b_mac_ff, b_mac_in;
   logic [AID_W-1:0]     best_ff, best_in;
   logic [SCW-1:0]       scan_cnt_ff, scan_cnt_in;
   logic [AID_W-1:0]     id_ff, id_in;
   logic                 held_ff, held_in;
   logic [COUNT_WIDTH-1:0] epoch_ff, epoch_in;
   response_type         rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // cell row
   cell_ctrl_type        ctrl;
   logic [MAX_PEERS-1:0] cell_we;
   slot_rec_type         wr_rec;
   logic [COUNT_WIDTH-1:0] wr_gen, wr_ep;
   logic [AID_W-1:0]     probe_id;
   logic [AID_W-1:0]     scan_link [MAX_PEERS+1];
   slot_rec_type         rec_arr [MAX_PEERS];
   logic [COUNT_WIDTH-1:0] gen_arr [MAX_PEERS];
   logic [COUNT_WIDTH-1:0] ep_arr [MAX_PEERS];
   cell_stat_type        stat_arr [MAX_PEERS];
   logic [MAX_PEERS-1:0] valid_vec, mac_hit_vec, aid_hit_vec, any_hit_vec;

   assign scan_link[MAX_PEERS] = '0;

   for (genvar i = 0; i < MAX_PEERS; i++) begin : g_cell
      wpat_cell #(.COUNT_WIDTH(COUNT_WIDTH)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .we        (cell_we[i]),
         .wr_rec    (wr_rec),
         .wr_gen    (wr_gen),
         .wr_ep     (wr_ep),
         .probe_mac (req_ff.peer_mac),
         .probe_id  (probe_id),
         .scan_in   (scan_link[i+1]),
         .scan_out  (scan_link[i]),
         .rec       (rec_arr[i]),
         .gen       (gen_arr[i]),
         .ep        (ep_arr[i]),
         .stat      (stat_arr[i])
      );
      assign valid_vec[i]   = stat_arr[i].valid;
      assign mac_hit_vec[i] = stat_arr[i].mac_hit;
      assign aid_hit_vec[i] = stat_arr[i].aid_hit;
      assign any_hit_vec[i] = stat_arr[i].any_hit;
   end

   // common terms
   logic [AID_W-1:0]     lim;
   logic [AID_W-1:0]     low_free;
   logic                 found;
   logic                 alloc_fail;
   logic [MAX_PEERS-1:0] view_oh;
   logic [MAX_PEERS-1:0] id_masked;
   logic [AID_W-1:0]     cand;
   logic [AID_W-1:0]     commit_id;
   logic                 apply_fire;

   assign lim        = (limit_ff > AID_TOP) ? AID_TOP : limit_ff;
   assign low_free   = (best_ff == AID_NONE) ? '0 : best_ff;
   assign found      = |mac_oh_ff;
   assign alloc_fail = !found && !(|free_oh_ff);
   assign view_oh    = (req_ff.req_type == REQ_LOOKUP_ID) ? id_oh_ff : mac_oh_ff;
   assign id_masked  = (req_ff.assoc_id != '0) ? aid_hit_vec : '0;
   assign cand       = (scan_cnt_ff == '0) ? AID_W'(1) : scan_link[0] + AID_W'(1);
   assign apply_fire = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      commit_id = req_ff.assoc_id;
      if (req_ff.assoc_id == '0) begin
         if (found && b_res_ff != '0) begin
            commit_id = b_res_ff;
         end else if (found && b_aid_ff != '0) begin
            commit_id = b_aid_ff;
         end else begin
            commit_id = low_free;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MATCH;
         end
         ST_MATCH: state_in = ST_VIEW;
         ST_VIEW:  state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_cnt_ff == SCAN_LAST) state_in = ST_CHECK;
         end
         ST_CHECK: state_in = ST_APPLY;
         ST_APPLY: begin
            if (apply_fire) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall  = 1'b1;
      ctrl.load  = 1'b0;
      ctrl.shift = 1'b0;
      probe_id   = req_ff.assoc_id;
      case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_MATCH: probe_id = req_ff.assoc_id;
         ST_VIEW:  ctrl.load = 1'b1;
         ST_SCAN: begin
            probe_id   = cand;
            ctrl.shift = (scan_cnt_ff != '0);
         end
         ST_CHECK: probe_id = commit_id;
         ST_APPLY: probe_id = req_ff.assoc_id;
         default:  req_stall = 1'b1;
      endcase
   end

   // match, view gather, scan and check
   always_comb begin
      req_in      = req_ff;
      limit_in    = csr_wr_en ? csr_wr_data : limit_ff;
      mac_oh_in   = mac_oh_ff;
      id_oh_in    = id_oh_ff;
      free_oh_in  = free_oh_ff;
      b_valid_in  = b_valid_ff;
      b_has_in    = b_has_ff;
      b_st_in     = b_st_ff;
      b_aid_in    = b_aid_ff;
      b_res_in    = b_res_ff;
      b_gen_in    = b_gen_ff;
      b_ep_in     = b_ep_ff;
      b_mac_in    = b_mac_ff;
      best_in     = best_ff;
      scan_cnt_in = scan_cnt_ff;
      id_in       = id_ff;
      held_in     = held_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) req_in = req_data;
         end
         ST_MATCH: begin
            mac_oh_in  = mac_hit_vec & (~mac_hit_vec + MAX_PEERS'(1));
            id_oh_in   = id_masked & (~id_masked + MAX_PEERS'(1));
            free_oh_in = ~valid_vec & (valid_vec + MAX_PEERS'(1));
         end
         ST_VIEW: begin
            b_valid_in  = |view_oh;
            b_has_in    = 1'b0;
            b_st_in     = '0;
            b_aid_in    = '0;
            b_res_in    = '0;
            b_gen_in    = '0;
            b_ep_in     = '0;
            b_mac_in    = '0;
            for (int i = 0; i < MAX_PEERS; i++) begin
               if (view_oh[i]) begin
                  b_has_in = b_has_in | rec_arr[i].has;
                  b_st_in  = b_st_in | (rec_arr[i].has ? rec_arr[i].st : 2'd0);
                  b_aid_in = b_aid_in | rec_arr[i].aid;
                  b_res_in = b_res_in | rec_arr[i].res;
                  b_gen_in = b_gen_in | gen_arr[i];
                  b_ep_in  = b_ep_in | ep_arr[i];
                  b_mac_in = b_mac_in | rec_arr[i].mac;
               end
            end
            best_in     = AID_NONE;
            scan_cnt_in = '0;
         end
         ST_SCAN: begin
            if (cand != '0 && cand <= lim && !(|any_hit_vec) && cand < best_ff) begin
               best_in = cand;
            end
            scan_cnt_in = scan_cnt_ff + SCW'(1);
         end
         ST_CHECK: begin
            id_in   = commit_id;
            held_in = |(aid_hit_vec & ~mac_oh_ff);
         end
         default: begin
            held_in = held_ff;
         end
      endcase
   end

   // decision and record update
   logic [3:0]             err;
   logic                   wr;
   logic                   show_res;
   logic                   bump;
   slot_rec_type           base;
   logic [COUNT_WIDTH-1:0] gen_adv;
   logic [AID_W-1:0]       rid;
   logic                   a_valid;
   slot_rec_type           a_rec;
   logic [COUNT_WIDTH-1:0] a_gen, a_ep;

   always_comb begin
      base = '{valid: 1'b1, mac: req_ff.peer_mac, has: 1'b0, st: 2'd0,
               aid: '0, res: '0};
      if (found) begin
         base = '{valid: 1'b1, mac: req_ff.peer_mac, has: b_has_ff, st: b_st_ff,
                  aid: b_aid_ff, res: b_res_ff};
      end
      gen_adv = b_gen_ff + COUNT_WIDTH'(1);
      if (gen_adv == '0) gen_adv = COUNT_WIDTH'(1);
      err      = ERR_OK;
      wr       = 1'b0;
      show_res = 1'b0;
      bump     = 1'b0;
      wr_rec   = base;
      wr_gen   = b_gen_ff;
      wr_ep    = b_ep_ff;
      rid      = (found && b_aid_ff != '0) ? b_aid_ff : low_free;
      case (req_ff.req_type)
         REQ_SET_STATUS: begin
            if (req_ff.member_status >= MS_ASSOCIATED) begin
               err = ERR_BAD_STATUS;
            end else if (b_ep_ff != '0) begin
               err = ERR_PEER_ASSOC;
            end else if (!b_has_ff || b_st_ff != req_ff.member_status) begin
               if (alloc_fail) begin
                  err = ERR_TABLE_FULL;
               end else begin
                  wr         = 1'b1;
                  wr_rec.has = 1'b1;
                  wr_rec.st  = req_ff.member_status;
                  wr_gen     = gen_adv;
               end
            end
         end
         REQ_RESERVE: begin
            if (found && b_res_ff != '0) begin
               show_res = 1'b1;
            end else if (rid == '0) begin
               err = ERR_NONE_FREE;
            end else if (alloc_fail) begin
               err = ERR_TABLE_FULL;
            end else begin
               wr         = 1'b1;
               wr_rec.res = rid;
               show_res   = 1'b1;
            end
         end
         REQ_RELEASE: begin
            if (found && b_res_ff != '0) begin
               if (b_res_ff != req_ff.assoc_id) begin
                  err = ERR_MISMATCH;
               end else begin
                  wr         = 1'b1;
                  wr_rec.res = '0;
                  if (!b_has_ff && b_aid_ff == '0 && b_gen_ff == '0 && b_ep_ff == '0) begin
                     wr_rec.valid = 1'b0;
                  end
               end
            end
         end
         REQ_COMMIT: begin
            if (req_ff.assoc_id == '0 && id_ff == '0) begin
               err = ERR_NONE_FREE;
            end else if (id_ff == '0 || id_ff > lim) begin
               err = ERR_ID_RANGE;
            end else if (found && b_res_ff != '0 && b_res_ff != id_ff) begin
               err = ERR_MISMATCH;
            end else if (held_ff) begin
               err = ERR_ID_USED;
            end else if (epoch_ff == CNT_MAX) begin
               err = ERR_EPOCH_EXH;
            end else if (alloc_fail) begin
               err = ERR_TABLE_FULL;
            end else begin
               wr         = 1'b1;
               bump       = 1'b1;
               wr_rec.has = 1'b1;
               wr_rec.st  = MS_ASSOCIATED;
               wr_rec.aid = id_ff;
               wr_rec.res = '0;
               if (!b_has_ff || b_st_ff != MS_ASSOCIATED || b_aid_ff != id_ff) begin
                  wr_gen = gen_adv;
               end
               wr_ep = epoch_ff + COUNT_WIDTH'(1);
            end
         end
         REQ_CLEAR: begin
            if (req_ff.member_status >= MS_ASSOCIATED) begin
               err = ERR_BAD_STATUS;
            end else if (alloc_fail) begin
               err = ERR_TABLE_FULL;
            end else begin
               wr         = 1'b1;
               wr_rec.has = 1'b1;
               wr_rec.st  = req_ff.member_status;
               wr_rec.aid = '0;
               wr_ep      = '0;
               if (!b_has_ff || b_st_ff != req_ff.member_status || b_aid_ff != '0 ||
                   b_ep_ff != '0) begin
                  wr_gen = gen_adv;
               end
            end
         end
         default: begin
            err = ERR_OK;
         end
      endcase
   end

   assign cell_we = (state_ff == ST_APPLY && apply_fire && wr) ?
                    (found ? mac_oh_ff : free_oh_ff) : '0;

   always_comb begin
      a_valid = wr ? wr_rec.valid : b_valid_ff;
      a_rec   = wr ? wr_rec : '{valid: b_valid_ff, mac: b_mac_ff, has: b_has_ff,
                                st: b_st_ff, aid: b_aid_ff, res: b_res_ff};
      a_gen   = wr ? wr_gen : b_gen_ff;
      a_ep    = wr ? wr_ep : b_ep_ff;
      rsp_in  = rsp_ff;
      epoch_in = epoch_ff;
      if (state_ff == ST_APPLY && apply_fire) begin
         if (bump) epoch_in = epoch_ff + COUNT_WIDTH'(1);
         rsp_in.error_code     = err;
         rsp_in.has_status     = a_valid && a_rec.has;
         rsp_in.status_out     = (a_valid && a_rec.has) ? a_rec.st : 2'd0;
         rsp_in.aid_out        = !a_valid ? '0 : (show_res ? a_rec.res : a_rec.aid);
         rsp_in.generation_out = a_valid ? 32'(a_gen) : 32'd0;
         rsp_in.epoch_out      = a_valid ? 32'(a_ep) : 32'd0;
         rsp_in.station_mac    = (req_ff.req_type == REQ_LOOKUP_ID) ? b_mac_ff : '0;
         rsp_in.old_has_status = b_has_ff;
         rsp_in.old_status     = b_st_ff;
         rsp_in.old_aid        = b_aid_ff;
         rsp_in.old_generation = 32'(b_gen_ff);
         rsp_in.old_epoch      = 32'(b_ep_ff);
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == ST_APPLY && apply_fire) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= AID_TOP;
         epoch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         epoch_ff     <= epoch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      mac_oh_ff   <= mac_oh_in;
      id_oh_ff    <= id_oh_in;
      free_oh_ff  <= free_oh_in;
      b_valid_ff  <= b_valid_in;
      b_has_ff    <= b_has_in;
      b_st_ff     <= b_st_in;
      b_aid_ff    <= b_aid_in;
      b_res_ff    <= b_res_in;
      b_gen_ff    <= b_gen_in;
      b_ep_ff     <= b_ep_in;
      b_mac_ff    <= b_mac_in;
      best_ff     <= best_in;
      scan_cnt_ff <= scan_cnt_in;
      id_ff       <= id_in;
      held_ff     <= held_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_we_only_apply: assert property (@(posedge clock) disable iff (reset)
      (|cell_we) |-> (state_ff == ST_APPLY))
      else $error("slot write outside apply");

   a_we_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_we))
      else $error("more than one slot written");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_cnt_ff <= SCAN_LAST))
      else $error("scan counter overrun");

   a_accept_match: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_MATCH))
      else $error("accepted request not matched");

   a_epoch_bump: assert property (@(posedge clock) disable iff (reset)
      (epoch_ff != $past(epoch_ff)) |-> ($past(state_ff) == ST_APPLY))
      else $error("epoch moved outside apply");

endmodule

// ===== test/peer_table_checker.sv =====
`timescale 1ns / 1ps
// Checker for the peer association table: predicts each response and compares it.
module peer_table_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  wpat_pkg::request_type      req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  wpat_pkg::response_type     rsp_data,
   input  logic                       csr_wr_en,
   input  logic [wpat_pkg::AID_W-1:0] csr_wr_data,
   output int                         fail_count,
   output int                         pending,
   output int                         checked_count
);
   import wpat_pkg::*;

   localparam int PEERS = 64;

   typedef struct packed {
      logic        has;
      logic [1:0]  st;
      logic [10:0] aid;
      logic [31:0] gen;
      logic [31:0] ep;
   } peer_view_type;

   bit          used[PEERS];
   logic [47:0] mac_of[PEERS];
   bit          has_st[PEERS];
   logic [1:0]  st_of[PEERS];
   logic [10:0] aid_of[PEERS];
   logic [10:0] res_of[PEERS];
   logic [31:0] gen_of[PEERS];
   logic [31:0] ep_of[PEERS];
   bit          id_busy[2048];
   logic [31:0] epoch_count;
   logic [10:0] id_limit;

   response_type expected_q[$];

   function automatic void clear_table();
      for (int i = 0; i < PEERS; i++) begin
         used[i] = 0;
         mac_of[i] = '0;
         has_st[i] = 0;
         st_of[i] = '0;
         aid_of[i] = '0;
         res_of[i] = '0;
         gen_of[i] = '0;
         ep_of[i] = '0;
      end
      for (int i = 0; i < 2048; i++) id_busy[i] = 0;
      epoch_count = '0;
      id_limit = AID_TOP;
   endfunction

   function automatic int find_peer(logic [47:0] mac);
      for (int i = 0; i < PEERS; i++)
         if (used[i] && mac_of[i] == mac) return i;
      return -1;
   endfunction

   function automatic int claim_slot(logic [47:0] mac);
      for (int i = 0; i < PEERS; i++)
         if (!used[i]) begin
            used[i] = 1;
            mac_of[i] = mac;
            has_st[i] = 0;
            st_of[i] = '0;
            aid_of[i] = '0;
            res_of[i] = '0;
            gen_of[i] = '0;
            ep_of[i] = '0;
            return i;
         end
      return -1;
   endfunction

   function automatic void update_id_busy(logic [10:0] id);
      bit busy;
      busy = 0;
      if (id != 0)
         for (int i = 0; i < PEERS; i++)
            if (used[i] && (aid_of[i] == id || res_of[i] == id)) busy = 1;
      id_busy[id] = busy;
   endfunction

   function automatic logic [10:0] first_free_id(logic [10:0] lim);
      for (int id = 1; id <= lim; id++)
         if (!id_busy[id]) return 11'(id);
      return '0;
   endfunction

   function automatic bit taken_elsewhere(logic [10:0] id, int s);
      for (int i = 0; i < PEERS; i++)
         if (i != s && used[i] && aid_of[i] == id) return 1;
      return 0;
   endfunction

   function automatic void bump_gen(int s);
      logic [31:0] g;
      g = gen_of[s] + 32'd1;
      gen_of[s] = (g == 0) ? 32'd1 : g;
   endfunction

   function automatic peer_view_type peer_view(int s, bit show_res);
      peer_view_type v;
      v = '0;
      if (s < 0) return v;
      if (!used[s]) return v;
      v.has = has_st[s];
      v.st = has_st[s] ? st_of[s] : 2'd0;
      v.aid = show_res ? res_of[s] : aid_of[s];
      v.gen = gen_of[s];
      v.ep = ep_of[s];
      return v;
   endfunction

   function automatic response_type predict_response(request_type r);
      response_type  o;
      peer_view_type pre;
      peer_view_type post;
      logic [10:0]   lim;
      logic [10:0]   id;
      logic [10:0]   prev_aid;
      logic [10:0]   prev_res;
      logic [3:0]    err;
      logic [47:0]   stn;
      bit            show_res;
      bit            changed;
      int            s;
      lim = (id_limit > AID_TOP) ? AID_TOP : id_limit;
      s = find_peer(r.peer_mac);
      pre = peer_view(s, 0);
      err = ERR_OK;
      show_res = 0;
      stn = '0;
      case (r.req_type)
         REQ_SET_STATUS: begin
            if (r.member_status >= 2) err = ERR_BAD_STATUS;
            else if (pre.ep != 0) err = ERR_PEER_ASSOC;
            else if (!pre.has || pre.st != r.member_status) begin
               if (s < 0) s = claim_slot(r.peer_mac);
               if (s < 0) err = ERR_TABLE_FULL;
               else begin
                  has_st[s] = 1;
                  st_of[s] = r.member_status;
                  bump_gen(s);
               end
            end
         end
         REQ_RESERVE: begin
            if (s >= 0 && res_of[s] != 0) show_res = 1;
            else begin
               id = (s >= 0 && aid_of[s] != 0) ? aid_of[s] : first_free_id(lim);
               if (id == 0) err = ERR_NONE_FREE;
               else begin
                  if (s < 0) s = claim_slot(r.peer_mac);
                  if (s < 0) err = ERR_TABLE_FULL;
                  else begin
                     res_of[s] = id;
                     update_id_busy(id);
                     show_res = 1;
                  end
               end
            end
         end
         REQ_RELEASE: begin
            if (s >= 0 && res_of[s] != 0) begin
               if (res_of[s] != r.assoc_id) err = ERR_MISMATCH;
               else begin
                  res_of[s] = '0;
                  update_id_busy(r.assoc_id);
                  if (!has_st[s] && aid_of[s] == 0 && gen_of[s] == 0 && ep_of[s] == 0)
                     used[s] = 0;
               end
            end
         end
         REQ_COMMIT: begin
            id = r.assoc_id;
            if (id == 0) begin
               if (s >= 0 && res_of[s] != 0) id = res_of[s];
               else if (s >= 0 && aid_of[s] != 0) id = aid_of[s];
               else id = first_free_id(lim);
               if (id == 0) err = ERR_NONE_FREE;
            end
            if (err == ERR_OK && (id < 1 || id > lim)) err = ERR_ID_RANGE;
            if (err == ERR_OK && s >= 0 && res_of[s] != 0 && res_of[s] != id)
               err = ERR_MISMATCH;
            if (err == ERR_OK && taken_elsewhere(id, s)) err = ERR_ID_USED;
            if (err == ERR_OK && epoch_count == '1) err = ERR_EPOCH_EXH;
            if (err == ERR_OK && s < 0) begin
               s = claim_slot(r.peer_mac);
               if (s < 0) err = ERR_TABLE_FULL;
            end
            if (err == ERR_OK) begin
               changed = !pre.has || pre.st != MS_ASSOCIATED || pre.aid != id;
               prev_aid = aid_of[s];
               prev_res = res_of[s];
               has_st[s] = 1;
               st_of[s] = MS_ASSOCIATED;
               aid_of[s] = id;
               res_of[s] = '0;
               update_id_busy(prev_aid);
               update_id_busy(prev_res);
               update_id_busy(id);
               if (changed) bump_gen(s);
               epoch_count = epoch_count + 32'd1;
               ep_of[s] = epoch_count;
            end
         end
         REQ_CLEAR: begin
            if (r.member_status >= 2) err = ERR_BAD_STATUS;
            else begin
               if (s < 0) s = claim_slot(r.peer_mac);
               if (s < 0) err = ERR_TABLE_FULL;
               else begin
                  changed = !pre.has || pre.st != r.member_status || pre.aid != 0 ||
                            pre.ep != 0;
                  prev_aid = aid_of[s];
                  has_st[s] = 1;
                  st_of[s] = r.member_status;
                  aid_of[s] = '0;
                  ep_of[s] = '0;
                  update_id_busy(prev_aid);
                  if (changed) bump_gen(s);
               end
            end
         end
         REQ_LOOKUP_ID: begin
            s = -1;
            if (r.assoc_id != 0)
               for (int i = 0; i < PEERS && s < 0; i++)
                  if (used[i] && aid_of[i] == r.assoc_id) s = i;
            pre = peer_view(s, 0);
            if (s >= 0) stn = mac_of[s];
         end
         default: ;
      endcase
      post = peer_view(s, show_res);
      o.error_code = err;
      o.has_status = post.has;
      o.status_out = post.st;
      o.aid_out = post.aid;
      o.generation_out = post.gen;
      o.epoch_out = post.ep;
      o.station_mac = stn;
      o.old_has_status = pre.has;
      o.old_status = pre.st;
      o.old_aid = pre.aid;
      o.old_generation = pre.gen;
      o.old_epoch = pre.ep;
      return o;
   endfunction

   always @(posedge clock) begin
      response_type want;
      response_type got;
      if (reset) begin
         clear_table();
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("tb: response with none outstanding: %h", got);
            end else begin
               want = expected_q.pop_front();
               checked_count++;
               if (got.error_code !== want.error_code ||
                   got.has_status !== want.has_status ||
                   got.status_out !== want.status_out ||
                   got.aid_out !== want.aid_out ||
                   got.generation_out !== want.generation_out ||
                   got.epoch_out !== want.epoch_out ||
                   got.station_mac !== want.station_mac ||
                   got.old_has_status !== want.old_has_status ||
                   got.old_status !== want.old_status ||
                   got.old_aid !== want.old_aid ||
                   got.old_generation !== want.old_generation ||
                   got.old_epoch !== want.old_epoch) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("tb: mismatch at response %0d", checked_count);
                     $display("   exp err=%0d st=%0d/%0d aid=%0d gen=%0d ep=%0d mac=%h",
                              want.error_code, want.has_status, want.status_out,
                              want.aid_out, want.generation_out, want.epoch_out,
                              want.station_mac);
                     $display("       old st=%0d/%0d aid=%0d gen=%0d ep=%0d",
                              want.old_has_status, want.old_status, want.old_aid,
                              want.old_generation, want.old_epoch);
                     $display("   got err=%0d st=%0d/%0d aid=%0d gen=%0d ep=%0d mac=%h",
                              got.error_code, got.has_status, got.status_out,
                              got.aid_out, got.generation_out, got.epoch_out,
                              got.station_mac);
                     $display("       old st=%0d/%0d aid=%0d gen=%0d ep=%0d",
                              got.old_has_status, got.old_status, got.old_aid,
                              got.old_generation, got.old_epoch);
                  end
               end
            end
         end
         if (csr_wr_en) id_limit = csr_wr_data;
         if (req_valid && !req_stall)
            expected_q.insert(expected_q.size(), predict_response(req_data));
      end
      pending = expected_q.size();
   end

endmodule

// ===== test/wlan_peer_association_table_unit_test.sv =====
`timescale 1ns / 1ps
// Top of the peer association table testbench: clock, reset, requests and verdict.
module wlan_peer_association_table_unit_test;
   import wpat_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int POOL_SIZE  = 72;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_stall;
   request_type          req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 0;
   response_type         rsp_data;
   logic                 csr_wr_en = 0;
   logic [AID_W-1:0]     csr_wr_data = '0;

   int fail_count;
   int pending;
   int checked_count;
   int sender_idle_pct = 0;
   int stall_pct = 0;
   int sent_count = 0;
   int setting_count = 0;
   int idle_cycles = 0;
   logic [47:0] mac_pool[POOL_SIZE];

   wlan_peer_association_table_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   peer_table_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending(pending), .checked_count(checked_count)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send(logic [2:0] op, logic [47:0] mac, logic [1:0] ms, logic [10:0] id);
      request_type r;
      r.req_type = op;
      r.peer_mac = mac;
      r.member_status = ms;
      r.assoc_id = id;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (140) @(posedge clock);
   endtask

   task automatic set_limit(logic [10:0] lim);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= lim;
      @(posedge clock);
      csr_wr_en <= 0;
      setting_count++;
   endtask

   function automatic logic [47:0] pick_mac();
      if ($urandom_range(9) == 0) return 48'({$urandom(), $urandom()});
      return mac_pool[$urandom_range(POOL_SIZE - 1)];
   endfunction

   function automatic logic [10:0] pick_id();
      case ($urandom_range(3))
         0: return 11'($urandom_range(8));
         1: return 11'($urandom_range(70));
         2: return 11'($urandom);
         default: return 11'($urandom_range(2007));
      endcase
   endfunction

   task automatic run_random(int count);
      logic [47:0] mac;
      int          done;
      done = 0;
      while (done < count) begin
         if ($urandom_range(99) < 60) begin
            mac = pick_mac();
            send(REQ_SET_STATUS, mac, 2'($urandom_range(1)), pick_id());
            send(REQ_RESERVE, mac, 2'($urandom), pick_id());
            send(REQ_COMMIT, mac, 2'($urandom), ($urandom_range(3) == 0) ? pick_id() : 11'd0);
            send(REQ_LOOKUP_ID, pick_mac(), 2'($urandom), pick_id());
            send(REQ_LOOKUP_MAC, mac, 2'($urandom), pick_id());
            if ($urandom_range(1)) begin
               send(REQ_CLEAR, mac, 2'($urandom_range(1)), pick_id());
               send(REQ_RELEASE, mac, 2'($urandom), pick_id());
               done += 2;
            end
            done += 5;
         end else begin
            send(3'($urandom), pick_mac(), 2'($urandom), pick_id());
            done++;
         end
      end
   endtask

   initial begin
      logic [47:0] m;
      for (int i = 0; i < POOL_SIZE; i++) mac_pool[i] = 48'({$urandom(), $urandom()});
      mac_pool[0] = '0;
      mac_pool[1] = '1;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      m = mac_pool[2];
      send(REQ_LOOKUP_ID, m, 2'd0, 11'd0);
      send(REQ_LOOKUP_MAC, m, 2'd0, 11'd0);
      send(REQ_SET_STATUS, m, 2'd3, 11'd0);
      send(REQ_SET_STATUS, m, 2'd2, 11'd0);
      send(REQ_SET_STATUS, m, 2'd1, 11'd0);
      send(REQ_SET_STATUS, m, 2'd1, 11'd0);
      send(REQ_RELEASE, m, 2'd0, 11'd5);
      send(REQ_RESERVE, m, 2'd0, 11'd0);
      send(REQ_RESERVE, m, 2'd0, 11'd0);
      send(REQ_RELEASE, m, 2'd0, 11'd9);
      send(REQ_COMMIT, m, 2'd0, 11'd7);
      send(REQ_COMMIT, m, 2'd0, 11'd0);
      send(REQ_SET_STATUS, m, 2'd0, 11'd0);
      send(REQ_COMMIT, mac_pool[0], 2'd3, 11'd1);
      send(REQ_COMMIT, mac_pool[1], 2'd3, 11'd2008);
      send(REQ_COMMIT, mac_pool[1], 2'd3, 11'd2007);
      send(REQ_RESERVE, mac_pool[0], 2'd0, 11'd0);
      send(REQ_RELEASE, mac_pool[0], 2'd0, 11'd2);
      send(REQ_LOOKUP_ID, m, 2'd0, 11'd1);
      send(REQ_LOOKUP_ID, m, 2'd0, 11'h7FF);
      send(3'd7, m, 2'd0, 11'd0);
      send(REQ_CLEAR, m, 2'd3, 11'd0);
      send(REQ_CLEAR, mac_pool[1], 2'd0, 11'd0);
      send(REQ_CLEAR, m, 2'd1, 11'd0);
      drain();

      set_limit(11'd3);
      run_random(200);
      sender_idle_pct = 66;
      set_limit(11'd0);
      run_random(200);
      run_random(80);
      sender_idle_pct = 0;
      stall_pct = 66;
      set_limit(11'd1);
      run_random(250);
      sender_idle_pct = 18;
      stall_pct = 18;
      set_limit(11'h7FF);
      run_random(300);
      sender_idle_pct = 0;
      stall_pct = 0;
      set_limit(11'd40);
      run_random(300);
      sender_idle_pct = 66;
      stall_pct = 66;
      set_limit(AID_TOP);
      run_random(250);
      sender_idle_pct = 18;
      stall_pct = 0;
      set_limit(11'd64);
      run_random(250);
      drain();
      repeat (300) @(posedge clock);

      $display("tb: %0d requests sent, %0d responses checked", sent_count, checked_count);
      $display("tb: %0d ID limit settings, idle and stall mixes from none to heavy",
               setting_count);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/wpat_pkg.sv
sv/wpat_cell.sv
sv/wlan_peer_association_table_unit.sv
test/peer_table_checker.sv
test/wlan_peer_association_table_unit_test.sv
